// ----- hdl/tgfw_pkg.sv -----
package tgfw_pkg;

	localparam logic [2:0] FN_SET_CURSOR = 3'd0;
	localparam logic [2:0] FN_DRAW       = 3'd1;
	localparam logic [2:0] FN_DRAW_ADV   = 3'd2;
	localparam logic [2:0] FN_PIXEL      = 3'd3;
	localparam logic [2:0] FN_CLEAR      = 3'd4;
	localparam logic [2:0] FN_READ       = 3'd5;

	localparam int GLYPH_W    = 4;
	localparam int GLYPH_H    = 6;
	localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;

	typedef struct packed {
		logic [GLYPH_H-1:0] bits;
		logic [GLYPH_H-1:0] mask;
		logic [2:0]         shift;
		logic               upper;
		logic [5:0]         page;
	} merge_req_t;

	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [128] = '{
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f45f,
		24'h01f45f, 24'h01f45f, 24'h01f45f, 24'h01f7df,
		24'h000000, 24'h0005c0, 24'h003003, 24'h01f29f,
		24'h0057ca, 24'h012109, 24'h01c5cf, 24'h0000c0,
		24'h011380, 24'h000391, 24'h005085, 24'h004384,
		24'h000210, 24'h004104, 24'h000400, 24'h003118,
		24'h00f45e, 24'h0007c2, 24'h012559, 24'h00a551,
		24'h01f107, 24'h009557, 24'h01d55e, 24'h003159,
		24'h01f55f, 24'h00f557, 24'h000280, 24'h000290,
		24'h011284, 24'h00a28a, 24'h004291, 24'h003541,
		24'h01654e, 24'h01e15e, 24'h00a55f, 24'h01144e,
		24'h00e45f, 24'h01555f, 24'h00515f, 24'h01d54e,
		24'h01f11f, 24'h0117d1, 24'h00f408, 24'h01b11f,
		24'h01041f, 24'h01f19f, 24'h01f39f, 24'h00e44e,
		24'h00215f, 24'h01e64e, 24'h01635f, 24'h009552,
		24'h0017c1, 24'h01f40f, 24'h007607, 24'h01f31f,
		24'h01b11b, 24'h003703, 24'h013559, 24'h01145f,
		24'h008102, 24'h01f451, 24'h002042, 24'h010410,
		24'h000081, 24'h01c59a, 24'h00c49f, 24'h01248c,
		24'h01f48c, 24'h01668c, 24'h005784, 24'h01ea8c,
		24'h01c09f, 24'h000740, 24'h01d810, 24'h01231f,
		24'h0107d1, 24'h01e39e, 24'h01c09e, 24'h00c48c,
		24'h00c4be, 24'h03e48c, 24'h00209c, 24'h00a794,
		24'h0127c2, 24'h01e40e, 24'h00e60e, 24'h01e71e,
		24'h012312, 24'h01ea06, 24'h01679a, 24'h0116c4,
		24'h0007c0, 24'h0046d1, 24'h002184, 24'h01f7df
	};

	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
		logic [GLYPH_BITS-1:0] g;
		if (code[7]) begin
			g = GLYPH_ROM[0];
		end else begin
			g = GLYPH_ROM[code[6:0]];
		end
		return g;
	endfunction

endpackage

// ----- hdl/tgfw_frame_store.sv -----
module tgfw_frame_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/tgfw_merge.sv -----
module tgfw_merge #(
	parameter int PANEL_HEIGHT = 64
) (
	input  tgfw_pkg::merge_req_t req,
	input  logic [7:0]           old_byte,
	output logic [7:0]           new_byte,
	output logic                 touch
);
	import tgfw_pkg::*;

	localparam logic [8:0] H9 = 9'(PANEL_HEIGHT);

	logic [15:0] bits16;
	logic [15:0] mask16;
	logic [7:0]  bits8;
	logic [7:0]  mask8;
	logic [7:0]  row_ok;

	always_comb begin
		bits16 = {10'b0, req.bits} << req.shift;
		mask16 = {10'b0, req.mask} << req.shift;
		bits8  = req.upper ? bits16[15:8] : bits16[7:0];
		for (int b = 0; b < 8; b++) begin
			row_ok[b] = (9'({req.page, 3'b000}) + 9'(b)) < H9;
		end
		mask8    = (req.upper ? mask16[15:8] : mask16[7:0]) & row_ok;
		new_byte = (old_byte & ~mask8) | (bits8 & mask8);
		touch    = |mask8;
	end

endmodule

// ----- hdl/text_glyph_framebuffer_writer.sv -----
// Steps from acceptance to the result beat: set cursor and unused codes go straight to
// the result; pixel and byte read pass once through ST_RD and ST_WR; a glyph draw reads
// and rewrites eight frame bytes in turn (two pages of four columns); clear rewrites all
// PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 at the defaults). One item at a time:
// in_ready is high only while idle, so a new item is taken only once the last result beat
// is issued. The single-port frame store sets the pace. Reset is asynchronous; afterwards
// a clearing pass of one byte per cycle over the whole store runs with in_ready low.
module text_glyph_framebuffer_writer #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] char_code,
	input  logic       pixel_on,
	input  logic [9:0] byte_index,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] cursor_x,
	output logic [7:0] cursor_y,
	output logic       clipped,
	output logic       text_done
);
	import tgfw_pkg::*;

	localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam logic [8:0]    W9       = 9'(PANEL_WIDTH);
	localparam logic [8:0]    H9       = 9'(PANEL_HEIGHT);
	localparam logic [5:0]    PC6      = 6'(PAGE_COUNT);
	localparam logic [10:0]   STORE11  = 11'(STORE_BYTES > 1024 ? 1024 : STORE_BYTES);
	localparam logic [AW-1:0] LAST_ADR = AW'(STORE_BYTES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_addr_q;
	logic                  clr_reply_q;
	logic [2:0]            func_q;
	logic [7:0]            base_col_q;
	logic [7:0]            row_q;
	logic [GLYPH_BITS-1:0] glyph_q;
	logic                  on_q;
	logic [9:0]            idx_q;
	logic                  eot_q;
	logic                  clip_q;
	logic [7:0]            rdata_q;
	logic [2:0]            step_q;
	logic [7:0]            cursor_col_q;
	logic [7:0]            cursor_row_q;
	logic                  out_valid_q;
	logic [7:0]            read_data_q;
	logic [7:0]            cursor_x_q;
	logic [7:0]            cursor_y_q;
	logic                  clipped_q;
	logic                  text_done_q;

	logic [1:0]    step_col;
	logic          step_upper;
	logic [8:0]    col9;
	logic [5:0]    page6;
	logic [14:0]   page_off;
	logic          draw_ok;
	logic          read_ok;
	logic          is_glyph;
	logic          last_step;
	logic [AW-1:0] step_addr;
	merge_req_t    mreq;
	logic [7:0]    merged;
	logic          touch;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic [8:0]    adv_col;
	logic [8:0]    adv_row;
	logic          glyph_clip;
	logic          pixel_clip;

	always_comb begin
		step_col   = step_q[2:1];
		step_upper = step_q[0];
		col9       = {1'b0, base_col_q} + {7'b0, step_col};
		page6      = {1'b0, row_q[7:3]} + {5'b0, step_upper};
		page_off   = {9'b0, page6} * {6'b0, W9};
		draw_ok    = (col9 < W9) && (page6 < PC6);
		read_ok    = {1'b0, idx_q} < STORE11;
		is_glyph   = (func_q == FN_DRAW) || (func_q == FN_DRAW_ADV);
		last_step  = is_glyph ? (step_q == 3'd7) : 1'b1;
		if (func_q == FN_READ) begin
			step_addr = AW'(idx_q);
		end else begin
			step_addr = AW'(page_off + 15'(col9));
		end

		mreq.shift = row_q[2:0];
		mreq.upper = step_upper;
		mreq.page  = page6;
		if (is_glyph) begin
			mreq.bits = glyph_q[step_col*GLYPH_H +: GLYPH_H];
			mreq.mask = '1;
		end else begin
			mreq.bits = {{(GLYPH_H-1){1'b0}}, on_q};
			mreq.mask = {{(GLYPH_H-1){1'b0}}, 1'b1};
		end

		ram_we    = 1'b0;
		ram_addr  = step_addr;
		ram_wdata = merged;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = '0;
		end else if (state_q == ST_WR) begin
			ram_we = draw_ok && touch && (is_glyph || (func_q == FN_PIXEL));
		end

		adv_col    = {1'b0, cursor_col_q} + 9'(GLYPH_W);
		adv_row    = {1'b0, cursor_row_q} + 9'(GLYPH_H);
		glyph_clip = ({1'b0, cursor_col_q} + 9'(GLYPH_W - 1) >= W9) ||
		             ({1'b0, cursor_row_q} + 9'(GLYPH_H - 1) >= H9);
		pixel_clip = ({1'b0, pos_x} >= W9) || ({1'b0, pos_y} >= H9);
	end

	tgfw_frame_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	tgfw_merge #(
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_merge (
		.req     (mreq),
		.old_byte(ram_rdata),
		.new_byte(merged),
		.touch   (touch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			clr_reply_q  <= 1'b0;
			step_q       <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADR) begin
						clr_addr_q <= '0;
						state_q    <= clr_reply_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						on_q    <= pixel_on;
						idx_q   <= byte_index;
						eot_q   <= end_of_text;
						step_q  <= '0;
						rdata_q <= '0;
						clip_q  <= 1'b0;
						case (func)
							FN_SET_CURSOR: begin
								cursor_col_q <= pos_x;
								cursor_row_q <= pos_y;
								state_q      <= ST_FIN;
							end
							FN_DRAW, FN_DRAW_ADV: begin
								base_col_q <= cursor_col_q;
								row_q      <= cursor_row_q;
								glyph_q    <= glyph_bits(char_code);
								clip_q     <= glyph_clip;
								state_q    <= ST_RD;
							end
							FN_PIXEL: begin
								base_col_q <= pos_x;
								row_q      <= pos_y;
								clip_q     <= pixel_clip;
								state_q    <= ST_RD;
							end
							FN_CLEAR: begin
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end
							FN_READ: begin
								state_q <= ST_RD;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (func_q == FN_READ) begin
						rdata_q <= read_ok ? ram_rdata : '0;
					end
					if (last_step) begin
						state_q <= ST_FIN;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						logic [7:0] col_n;
						logic [7:0] row_n;
						col_n = cursor_col_q;
						row_n = cursor_row_q;
						if (func_q == FN_DRAW_ADV) begin
							if (adv_col > W9 - 9'(GLYPH_W)) begin
								col_n = '0;
								row_n = adv_row[8] ? 8'hff : adv_row[7:0];
							end else begin
								col_n = adv_col[7:0];
							end
						end
						cursor_col_q <= col_n;
						cursor_row_q <= row_n;
						cursor_x_q   <= col_n;
						cursor_y_q   <= row_n;
						read_data_q  <= rdata_q;
						clipped_q    <= clip_q;
						text_done_q  <= is_glyph & eot_q;
						out_valid_q  <= 1'b1;
						clr_reply_q  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign cursor_x  = cursor_x_q;
	assign cursor_y  = cursor_y_q;
	assign clipped   = clipped_q;
	assign text_done = text_done_q;

endmodule
